// ----- sv/btrl_pkg.sv -----
// Shared types and codes for the binary trie route lookup block.
`timescale 1ns / 1ps

package btrl_pkg;

    localparam int PORT_W = 8;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic at_end;
        logic has_child;
        logic pool_full;
    } step_flags_t;

endpackage

// ----- sv/btrl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module btrl_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/btrl_step.sv -----
// Per-level trie step unit: decodes a node word and decides the next move.
`timescale 1ns / 1ps

module btrl_step #(
    parameter int NODE_COUNT   = 1024,
    parameter int ADDRESS_BITS = 32
) (
    input  logic [2*$clog2(NODE_COUNT)+btrl_pkg::PORT_W-1:0] node_word,
    input  logic                                    zero_node,
    input  logic                                    addr_bit,
    input  logic [$clog2(ADDRESS_BITS+1)-1:0]       level,
    input  logic [$clog2(ADDRESS_BITS+1)-1:0]       target_len,
    input  logic [$clog2(NODE_COUNT+1)-1:0]         free_node,
    output btrl_pkg::step_flags_t                   flags,
    output logic [$clog2(NODE_COUNT)-1:0]           child,
    output logic [$clog2(NODE_COUNT)-1:0]           link_zero,
    output logic [$clog2(NODE_COUNT)-1:0]           link_one,
    output logic [btrl_pkg::PORT_W-1:0]             node_port
);

    localparam int LW  = $clog2(NODE_COUNT);
    localparam int NFW = $clog2(NODE_COUNT+1);
    localparam int PW  = btrl_pkg::PORT_W;

    logic [2*LW+PW-1:0] word;
    logic [LW-1:0]      raw_child;

    assign word      = zero_node ? '0 : node_word;
    assign link_one  = word[2*LW+PW-1:LW+PW];
    assign link_zero = word[LW+PW-1:PW];
    assign node_port = word[PW-1:0];
    assign raw_child = addr_bit ? link_one : link_zero;

    always_comb begin
        child = ({1'b0, raw_child} < (LW+1)'(NODE_COUNT)) ? raw_child : '0;
        flags.at_end    = (level == target_len);
        flags.has_child = (child != '0);
        flags.pool_full = (free_node >= NFW'(NODE_COUNT));
    end

endmodule

// ----- sv/binary_trie_route_lookup.sv -----
// Top level: IPv4 longest-prefix route table held as a binary trie in a node RAM.
`timescale 1ns / 1ps

// Each beat either adds a route (action 0) or looks up an address (action 1)
// and returns exactly one result beat. The trie is walked one level per cycle
// through a single node RAM read port; an item passes through the accept,
// one walk step per level visited (prefix length + 1 for an add, up to
// ADDRESS_BITS + 1 for a lookup) and the result beat. The block takes one
// item at a time and is not ready until the result beat has been taken. An
// add that runs out of nodes returns status 1; nodes already allocated stay
// with port 0.

module binary_trie_route_lookup #(
    parameter int NODE_COUNT   = 1024,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [ADDRESS_BITS-1:0]             s_prefix_value,
    input  logic [$clog2(ADDRESS_BITS+1)-1:0]   s_prefix_length,
    input  logic [btrl_pkg::PORT_W-1:0]         s_route_port,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [btrl_pkg::PORT_W-1:0]         m_found_port,
    output logic                                m_status
);

    localparam int LW  = $clog2(NODE_COUNT);
    localparam int NFW = $clog2(NODE_COUNT+1);
    localparam int LVW = $clog2(ADDRESS_BITS+1);
    localparam int PW  = btrl_pkg::PORT_W;
    localparam int NW  = 2*LW + PW;

    btrl_pkg::state_t state_reg, state_next;

    logic                    action_reg, action_next;
    logic [ADDRESS_BITS-1:0] value_reg, value_next;
    logic [LVW-1:0]          target_reg, target_next;
    logic [LVW-1:0]          level_reg, level_next;
    logic [PW-1:0]           port_reg, port_next;
    logic [PW-1:0]           best_reg, best_next;
    logic [LW-1:0]           cur_reg, cur_next;
    logic                    empty_reg, empty_next;
    logic [NFW-1:0]          free_reg, free_next;
    logic                    root_valid_reg, root_valid_next;
    logic [PW-1:0]           found_reg, found_next;
    logic                    status_reg, status_next;

    logic                  accept;
    logic                  wr_en;
    logic [NW-1:0]         wr_data;
    logic                  rd_en;
    logic [LW-1:0]         rd_addr;
    logic [NW-1:0]         rd_data;
    logic                  zero_node;
    btrl_pkg::step_flags_t flags;
    logic [LW-1:0]         child;
    logic [LW-1:0]         link_zero;
    logic [LW-1:0]         link_one;
    logic [PW-1:0]         node_port;
    logic [PW-1:0]         best_upd;
    logic [LW-1:0]         new_node;

    assign s_ready      = (state_reg == btrl_pkg::ST_IDLE);
    assign m_valid      = (state_reg == btrl_pkg::ST_DONE);
    assign m_found_port = found_reg;
    assign m_status     = status_reg;
    assign accept       = s_valid && s_ready;

    assign zero_node = empty_reg || ((cur_reg == '0) && !root_valid_reg);
    assign best_upd  = (node_port != '0) ? node_port : best_reg;
    assign new_node  = free_reg[LW-1:0];

    btrl_ram #(
        .WIDTH(NW),
        .DEPTH(NODE_COUNT)
    ) u_node_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(cur_reg),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    btrl_step #(
        .NODE_COUNT  (NODE_COUNT),
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_step (
        .node_word (rd_data),
        .zero_node (zero_node),
        .addr_bit  (value_reg[ADDRESS_BITS-1]),
        .level     (level_reg),
        .target_len(target_reg),
        .free_node (free_reg),
        .flags     (flags),
        .child     (child),
        .link_zero (link_zero),
        .link_one  (link_one),
        .node_port (node_port)
    );

    always_comb begin
        state_next      = state_reg;
        action_next     = action_reg;
        value_next      = value_reg;
        target_next     = target_reg;
        level_next      = level_reg;
        port_next       = port_reg;
        best_next       = best_reg;
        cur_next        = cur_reg;
        empty_next      = empty_reg;
        free_next       = free_reg;
        root_valid_next = root_valid_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_data         = {link_one, link_zero, node_port};
        rd_en           = 1'b0;
        rd_addr         = child;

        case (state_reg)
            btrl_pkg::ST_IDLE: begin
                if (accept) begin
                    action_next = s_action;
                    value_next  = s_prefix_value;
                    port_next   = s_route_port;
                    level_next  = '0;
                    best_next   = '0;
                    cur_next    = '0;
                    empty_next  = 1'b0;
                    if (s_action == btrl_pkg::ACT_LOOKUP) begin
                        target_next = LVW'(ADDRESS_BITS);
                    end else if (s_prefix_length > LVW'(ADDRESS_BITS)) begin
                        target_next = LVW'(ADDRESS_BITS);
                    end else begin
                        target_next = s_prefix_length;
                    end
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = btrl_pkg::ST_WALK;
                end
            end
            btrl_pkg::ST_WALK: begin
                if (action_reg == btrl_pkg::ACT_LOOKUP) begin
                    best_next = best_upd;
                    if (flags.at_end || !flags.has_child) begin
                        found_next  = best_upd;
                        status_next = btrl_pkg::STATUS_OK;
                        state_next  = btrl_pkg::ST_DONE;
                    end else begin
                        rd_en      = 1'b1;
                        cur_next   = child;
                        level_next = level_reg + LVW'(1);
                        value_next = value_reg << 1;
                    end
                end else begin
                    found_next = '0;
                    if (flags.at_end) begin
                        wr_en       = 1'b1;
                        wr_data     = {link_one, link_zero, port_reg};
                        status_next = btrl_pkg::STATUS_OK;
                        state_next  = btrl_pkg::ST_DONE;
                    end else if (flags.has_child) begin
                        rd_en      = 1'b1;
                        cur_next   = child;
                        level_next = level_reg + LVW'(1);
                        value_next = value_reg << 1;
                    end else if (flags.pool_full) begin
                        // clears a freshly allocated node, rewrites others unchanged
                        wr_en       = 1'b1;
                        status_next = btrl_pkg::STATUS_FULL;
                        state_next  = btrl_pkg::ST_DONE;
                    end else begin
                        wr_en = 1'b1;
                        if (value_reg[ADDRESS_BITS-1]) begin
                            wr_data = {new_node, link_zero, node_port};
                        end else begin
                            wr_data = {link_one, new_node, node_port};
                        end
                        cur_next   = new_node;
                        empty_next = 1'b1;
                        free_next  = free_reg + NFW'(1);
                        level_next = level_reg + LVW'(1);
                        value_next = value_reg << 1;
                    end
                end
                if (wr_en && (cur_reg == '0)) begin
                    root_valid_next = 1'b1;
                end
            end
            btrl_pkg::ST_DONE: begin
                if (m_ready) begin
                    state_next = btrl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = btrl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= btrl_pkg::ST_IDLE;
            free_reg       <= NFW'(1);
            root_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_reg       <= free_next;
            root_valid_reg <= root_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        value_reg  <= value_next;
        target_reg <= target_next;
        level_reg  <= level_next;
        port_reg   <= port_next;
        best_reg   <= best_next;
        cur_reg    <= cur_next;
        empty_reg  <= empty_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

endmodule
